### rtl/lru_key_value_cache_top_assert.svh
// Assertion macros shared by the cache top level.
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH

// Checked only while out of reset.
`define LKC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LKC_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lkc_pkg.sv
package lkc_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 31;
	localparam int VALUE_BITS = 32;
	localparam int CAP_BITS   = 5;
	localparam int CAP_RESET  = 16;

	localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_BITS  = $clog2(ENTRIES + 1);

	localparam int QDEPTH    = 2;
	localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic                  is_put;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic                busy;
		logic [OCC_BITS-1:0] occ;
		logic [ENTRIES-1:0]  valid;
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD
	} eng_state_t;

	// Clamp the capacity register into 1..ENTRIES.
	function automatic logic [OCC_BITS-1:0] eff_capacity(input logic [CAP_BITS-1:0] c);
		logic [OCC_BITS-1:0] r;
		if (c == '0)
			r = OCC_BITS'(1);
		else if (32'(c) > 32'(ENTRIES))
			r = OCC_BITS'(ENTRIES);
		else
			r = OCC_BITS'(c);
		return r;
	endfunction

endpackage

### rtl/lkc_front.sv
module lkc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [lkc_pkg::KEY_BITS-1:0]   lookup_key,
	input  logic [lkc_pkg::VALUE_BITS-1:0] write_value,
	output logic                         head_valid,
	output lkc_pkg::req_t                head,
	input  logic                         pop
);

	lkc_pkg::req_t                    queue_q [lkc_pkg::QDEPTH];
	logic [lkc_pkg::QPTR_BITS-1:0]    wr_ptr_q;
	logic [lkc_pkg::QPTR_BITS-1:0]    rd_ptr_q;
	logic [lkc_pkg::QCNT_BITS-1:0]    count_q;
	logic                             push;
	lkc_pkg::req_t                    req_in;

	assign in_stall   = (count_q == lkc_pkg::QCNT_BITS'(lkc_pkg::QDEPTH));
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != '0);
	assign head       = queue_q[rd_ptr_q];

	// Classify the request.
	always_comb begin
		req_in.is_put = (op == lkc_pkg::OP_PUT);
		req_in.key    = lookup_key;
		req_in.value  = write_value;
	end

	function automatic logic [lkc_pkg::QPTR_BITS-1:0] ptr_next(
		input logic [lkc_pkg::QPTR_BITS-1:0] p);
		logic [lkc_pkg::QPTR_BITS-1:0] r;
		if (32'(p) == lkc_pkg::QDEPTH - 1)
			r = '0;
		else
			r = p + lkc_pkg::QPTR_BITS'(1);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + lkc_pkg::QCNT_BITS'(1);
			else if (pop && !push)
				count_q <= count_q - lkc_pkg::QCNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= req_in;
	end

endmodule

### rtl/lkc_back.sv
module lkc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  lkc_pkg::req_t                   head,
	output logic                            pop,
	input  logic [lkc_pkg::OCC_BITS-1:0]    eff_cap,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic [lkc_pkg::VALUE_BITS-1:0]  read_value,
	output lkc_pkg::status_t                status
);

	localparam int N  = lkc_pkg::ENTRIES;
	localparam int IW = lkc_pkg::IDX_BITS;
	localparam int OW = lkc_pkg::OCC_BITS;

	lkc_pkg::eng_state_t           state_q;
	lkc_pkg::eng_state_t           state_nxt;
	lkc_pkg::req_t                 req_q;

	logic [lkc_pkg::KEY_BITS-1:0]   key_q   [N];
	logic [lkc_pkg::VALUE_BITS-1:0] val_q   [N];
	logic [IW-1:0]                  rank_q  [N];
	logic [N-1:0]                   valid_q;
	logic [OW-1:0]                  occ_q;

	// Lookup results, held for the update cycle.
	logic                          match_q;
	logic [IW-1:0]                 hit_idx_q;
	logic [IW-1:0]                 hit_rank_q;
	logic                          evict_q;
	logic [IW-1:0]                 evict_idx_q;
	logic [IW-1:0]                 slot_q;

	logic                          out_valid_q;
	logic                          hit_q;
	logic [lkc_pkg::VALUE_BITS-1:0] read_value_q;

	logic [N-1:0]  match_vec;
	logic [N-1:0]  evict_vec;
	logic [N-1:0]  free_vec;
	logic          match_any;
	logic [IW-1:0] match_idx;
	logic          evict_need;
	logic [IW-1:0] evict_idx;
	logic [IW-1:0] slot_idx;
	logic          out_free;
	logic          upd_fire;

	function automatic logic [IW-1:0] first_set(input logic [N-1:0] v);
		logic [IW-1:0] r;
		r = '0;
		for (int i = N - 1; i >= 0; i--)
			if (v[i])
				r = IW'(i);
		return r;
	endfunction

	assign out_free = !out_valid_q || !out_stall;

	// Parallel tag compare and victim / free slot search.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			match_vec[i] = valid_q[i] && (key_q[i] == req_q.key);
			evict_vec[i] = valid_q[i] && (OW'(rank_q[i]) == occ_q - OW'(1));
		end
		match_any  = |match_vec;
		match_idx  = first_set(match_vec);
		evict_need = !match_any && req_q.is_put && (occ_q >= eff_cap);
		evict_idx  = first_set(evict_vec);
		free_vec   = ~valid_q;
		if (evict_need)
			free_vec[evict_idx] = 1'b1;
		slot_idx   = first_set(free_vec);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lkc_pkg::ST_IDLE: begin
				if (head_valid)
					state_nxt = lkc_pkg::ST_LOOK;
			end
			lkc_pkg::ST_LOOK: state_nxt = lkc_pkg::ST_UPD;
			lkc_pkg::ST_UPD: begin
				if (out_free)
					state_nxt = lkc_pkg::ST_IDLE;
			end
			default: state_nxt = lkc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		upd_fire = 1'b0;
		case (state_q)
			lkc_pkg::ST_IDLE: pop      = head_valid;
			lkc_pkg::ST_UPD:  upd_fire = out_free;
			default: begin
				pop      = 1'b0;
				upd_fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lkc_pkg::ST_IDLE;
			valid_q     <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < N; i++)
				rank_q[i] <= '0;
		end else begin
			state_q <= state_nxt;
			if (upd_fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (upd_fire && match_q) begin
				// Promote the hit entry; anything more recent moves back one.
				for (int i = 0; i < N; i++)
					if (valid_q[i] && rank_q[i] < hit_rank_q)
						rank_q[i] <= rank_q[i] + IW'(1);
				rank_q[hit_idx_q] <= '0;
			end else if (upd_fire && req_q.is_put) begin
				for (int i = 0; i < N; i++) begin
					if (IW'(i) == slot_q) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (evict_q && IW'(i) == evict_idx_q) begin
						valid_q[i] <= 1'b0;
						rank_q[i]  <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
				if (!evict_q)
					occ_q <= occ_q + OW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			req_q <= head;
		if (state_q == lkc_pkg::ST_LOOK) begin
			match_q     <= match_any;
			hit_idx_q   <= match_idx;
			hit_rank_q  <= rank_q[match_idx];
			evict_q     <= evict_need;
			evict_idx_q <= evict_idx;
			slot_q      <= slot_idx;
		end
		if (upd_fire) begin
			hit_q <= match_q;
			if (match_q && !req_q.is_put)
				read_value_q <= val_q[hit_idx_q];
			else
				read_value_q <= '1;
			if (match_q && req_q.is_put)
				val_q[hit_idx_q] <= req_q.value;
			else if (req_q.is_put) begin
				key_q[slot_q] <= req_q.key;
				val_q[slot_q] <= req_q.value;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

	always_comb begin
		status.busy  = (state_q != lkc_pkg::ST_IDLE);
		status.occ   = occ_q;
		status.valid = valid_q;
	end

endmodule

### rtl/lru_key_value_cache_top.sv
// Channel   Direction  Handshake           Payload
// request   in         in_valid/in_stall   op, lookup_key, write_value
// response  out        out_valid/out_stall hit, read_value
// config    in         cfg_valid/cfg_ready cfg_data (capacity)
//
// Each request passes through the engine's dequeue, tag compare and table update states;
// the update state waits while the response register is full and stalled.
// A 2-deep request queue lets the request side keep moving while the engine works.
// arst_n clears the valid bits, recency ranks, occupancy and queue; capacity resets to 16.
// Keys and values hold garbage until written and are only read behind a valid bit.
`include "lru_key_value_cache_top_assert.svh"

module lru_key_value_cache_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              op,
	input  logic [lkc_pkg::KEY_BITS-1:0]      lookup_key,
	input  logic [lkc_pkg::VALUE_BITS-1:0]    write_value,
	// response channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [lkc_pkg::VALUE_BITS-1:0]    read_value,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lkc_pkg::CAP_BITS-1:0]      cfg_data
);

	logic [lkc_pkg::CAP_BITS-1:0] capacity_q;
	logic [lkc_pkg::OCC_BITS-1:0] eff_cap;
	logic                         head_valid;
	lkc_pkg::req_t                head;
	logic                         pop;
	lkc_pkg::status_t             status;

	// The user must write capacity only while idle; the block does not enforce it, so always take the transaction.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			capacity_q <= lkc_pkg::CAP_BITS'(lkc_pkg::CAP_RESET);
		else if (cfg_valid && cfg_ready)
			capacity_q <= cfg_data;
	end

	// Clamp into 1..ENTRIES before the engine sees it.
	assign eff_cap = lkc_pkg::eff_capacity(capacity_q);

	// Front: accept, classify and queue requests.
	lkc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop)
	);

	// Back: lookup, LRU update and response register.
	lkc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.eff_cap    (eff_cap),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.read_value (read_value),
		.status     (status)
	);

	// Drop a dequeue only on a non-empty queue.
	`LKC_ASSERT(a_pop_nonempty, pop |-> head_valid, "dequeue from empty request queue")
	// Hold the engine busy after taking a transaction.
	`LKC_ASSERT(a_pop_busy, pop |=> status.busy, "engine idle after dequeue")
	// Keep occupancy in step with the valid bits.
	`LKC_ASSERT(a_occ_count, $countones(status.valid) == 32'(status.occ), "occupancy does not match valid entries")
	// Bound occupancy by the table size.
	`LKC_ASSERT(a_occ_bound, 32'(status.occ) <= lkc_pkg::ENTRIES, "occupancy overflow")

endmodule
